// ===== src/streebog_hash_core_assert.svh =====
// assertion macros for the checker module
`ifndef STREEBOG_HASH_CORE_ASSERT_SVH
`define STREEBOG_HASH_CORE_ASSERT_SVH

// expression must never hold outside reset
`define SBH_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
		else $error("streebog assertion failed");

// antecedent implies consequent in the following cycle
`define SBH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("streebog assertion failed");

`endif

// ===== src/sbh_pkg.sv =====
// ----------------------------------------------------------------------------
// sbh_pkg
// Tables, state codes and the shared lps word function for the streebog core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbh_pkg;

	localparam int ROUNDS = 12;

	typedef logic [7:0][63:0] blk_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PAD, ST_LOAD, ST_LPS, ST_FOLD, ST_ADDN, ST_ADDS, ST_OUT
	} state_t;

	typedef enum logic [1:0] {PH_KINIT, PH_SLPS, PH_KLPS} phase_t;

	typedef enum logic [1:0] {JOB_BLOCK, JOB_CNT, JOB_SUM} job_t;

	localparam logic [7:0] SBOX [256] = '{
		252,238,221,17,207,110,49,22,251,196,250,218,35,197,4,77,
		233,119,240,219,147,46,153,186,23,54,241,187,20,205,95,193,
		249,24,101,90,226,92,239,33,129,28,60,66,139,1,142,79,
		5,132,2,174,227,106,143,160,6,11,237,152,127,212,211,31,
		235,52,44,81,234,200,72,171,242,42,104,162,253,58,206,204,
		181,112,14,86,8,12,118,18,191,114,19,71,156,183,93,135,
		21,161,150,41,16,123,154,199,243,145,120,111,157,158,178,177,
		50,117,25,61,255,53,138,126,109,84,198,128,195,189,13,87,
		223,245,36,169,62,168,67,201,215,121,214,246,124,34,185,3,
		224,15,236,222,122,148,176,188,220,232,40,80,78,51,10,74,
		167,151,96,115,30,0,98,68,26,184,56,130,100,159,38,65,
		173,69,70,146,39,94,85,47,140,163,165,125,105,213,149,59,
		7,88,179,64,134,172,29,247,48,55,107,228,136,217,231,137,
		225,27,131,73,76,63,248,254,141,83,170,144,202,216,133,97,
		32,113,103,164,45,43,9,91,203,155,37,208,190,229,108,82,
		89,166,116,210,230,244,180,192,209,102,175,194,57,75,99,182
	};

	localparam logic [63:0] LIN [64] = '{
		64'h8e20faa72ba0b470, 64'h47107ddd9b505a38, 64'had08b0e0c3282d1c, 64'hd8045870ef14980e,
		64'h6c022c38f90a4c07, 64'h3601161cf205268d, 64'h1b8e0b0e798c13c8, 64'h83478b07b2468764,
		64'ha011d380818e8f40, 64'h5086e740ce47c920, 64'h2843fd2067adea10, 64'h14aff010bdd87508,
		64'h0ad97808d06cb404, 64'h05e23c0468365a02, 64'h8c711e02341b2d01, 64'h46b60f011a83988e,
		64'h90dab52a387ae76f, 64'h486dd4151c3dfdb9, 64'h24b86a840e90f0d2, 64'h125c354207487869,
		64'h092e94218d243cba, 64'h8a174a9ec8121e5d, 64'h4585254f64090fa0, 64'haccc9ca9328a8950,
		64'h9d4df05d5f661451, 64'hc0a878a0a1330aa6, 64'h60543c50de970553, 64'h302a1e286fc58ca7,
		64'h18150f14b9ec46dd, 64'h0c84890ad27623e0, 64'h0642ca05693b9f70, 64'h0321658cba93c138,
		64'h86275df09ce8aaa8, 64'h439da0784e745554, 64'hafc0503c273aa42a, 64'hd960281e9d1d5215,
		64'he230140fc0802984, 64'h71180a8960409a42, 64'hb60c05ca30204d21, 64'h5b068c651810a89e,
		64'h456c34887a3805b9, 64'hac361a443d1c8cd2, 64'h561b0d22900e4669, 64'h2b838811480723ba,
		64'h9bcf4486248d9f5d, 64'hc3e9224312c8c1a0, 64'heffa11af0964ee50, 64'hf97d86d98a327728,
		64'he4fa2054a80b329c, 64'h727d102a548b194e, 64'h39b008152acb8227, 64'h9258048415eb419d,
		64'h492c024284fbaec0, 64'haa16012142f35760, 64'h550b8e9e21f7a530, 64'ha48b474f9ef5dc18,
		64'h70a6a56e2440598e, 64'h3853dc371220a247, 64'h1ca76e95091051ad, 64'h0edd37c48a08a6d8,
		64'h07e095624504536c, 64'h8d70c431ac02a736, 64'hc83862965601dd1b, 64'h641c314b2b8ee083
	};

	localparam logic [63:0] RC [ROUNDS][8] = '{
		'{64'hb1085bda1ecadae9, 64'hebcb2f81c0657c1f, 64'h2f6a76432e45d016, 64'h714eb88d7585c4fc,
		  64'h4b7ce09192676901, 64'ha2422a08a460d315, 64'h05767436cc744d23, 64'hdd806559f2a64507},
		'{64'h6fa3b58aa99d2f1a, 64'h4fe39d460f70b5d7, 64'hf3feea720a232b98, 64'h61d55e0f16b50131,
		  64'h9ab5176b12d69958, 64'h5cb561c2db0aa7ca, 64'h55dda21bd7cbcd56, 64'he679047021b19bb7},
		'{64'hf574dcac2bce2fc7, 64'h0a39fc286a3d8435, 64'h06f15e5f529c1f8b, 64'hf2ea7514b1297b7b,
		  64'hd3e20fe490359eb1, 64'hc1c93a376062db09, 64'hc2b6f443867adb31, 64'h991e96f50aba0ab2},
		'{64'hef1fdfb3e81566d2, 64'hf948e1a05d71e4dd, 64'h488e857e335c3c7d, 64'h9d721cad685e353f,
		  64'ha9d72c82ed03d675, 64'hd8b71333935203be, 64'h3453eaa193e837f1, 64'h220cbebc84e3d12e},
		'{64'h4bea6bacad474799, 64'h9a3f410c6ca92363, 64'h7f151c1f1686104a, 64'h359e35d7800fffbd,
		  64'hbfcd1747253af5a3, 64'hdfff00b723271a16, 64'h7a56a27ea9ea63f5, 64'h601758fd7c6cfe57},
		'{64'hae4faeae1d3ad3d9, 64'h6fa4c33b7a3039c0, 64'h2d66c4f95142a46c, 64'h187f9ab49af08ec6,
		  64'hcffaa6b71c9ab7b4, 64'h0af21f66c2bec6b6, 64'hbf71c57236904f35, 64'hfa68407a46647d6e},
		'{64'hf4c70e16eeaac5ec, 64'h51ac86febf240954, 64'h399ec6c7e6bf87c9, 64'hd3473e33197a93c9,
		  64'h0992abc52d822c37, 64'h06476983284a0504, 64'h3517454ca23c4af3, 64'h8886564d3a14d493},
		'{64'h9b1f5b424d93c9a7, 64'h03e7aa020c6e4141, 64'h4eb7f8719c36de1e, 64'h89b4443b4ddbc49a,
		  64'hf4892bcb929b0690, 64'h69d18d2bd1a5c42f, 64'h36acc2355951a8d9, 64'ha47f0dd4bf02e71e},
		'{64'h378f5a541631229b, 64'h944c9ad8ec165fde, 64'h3a7d3a1b25894224, 64'h3cd955b7e00d0984,
		  64'h800a440bdbb2ceb1, 64'h7b2b8a9aa6079c54, 64'h0e38dc92cb1f2a60, 64'h7261445183235adb},
		'{64'habbedea680056f52, 64'h382ae548b2e4f3f3, 64'h8941e71cff8a78db, 64'h1fffe18a1b336103,
		  64'h9fe76702af69334b, 64'h7a1e6c303b7652f4, 64'h3698fad1153bb6c3, 64'h74b4c7fb98459ced},
		'{64'h7bcd9ed0efc889fb, 64'h3002c6cd635afe94, 64'hd8fa6bbbebab0761, 64'h2001802114846679,
		  64'h8a1d71efea48b9ca, 64'hefbacd1d7d476e98, 64'hdea2594ac06fd85d, 64'h6bcaa4cd81f32d1b},
		'{64'h378ee767f11631ba, 64'hd21380b00449b17a, 64'hcda43c32bcdf1d77, 64'hf82012d430219f9b,
		  64'h5d80ef9d1891cc86, 64'he71da4aa88e12852, 64'hfaf417d5d9b21b99, 64'h48bc924af11bd720}
	};

	// one output word of the lps transform: byte i of every source word
	function automatic logic [63:0] lps_word(input blk_t t, input logic [2:0] i);
		logic [63:0] acc;
		logic [7:0]  b;
		logic [2:0]  sh;
		acc = '0;
		sh  = 3'(3'd7 - i);
		for (int j = 0; j < 8; j++) begin
			b = SBOX[t[j][{sh, 3'b000} +: 8]];
			for (int k = 0; k < 8; k++) begin
				if (b[7-k]) begin
					acc = acc ^ LIN[j*8+k];
				end
			end
		end
		return acc;
	endfunction

	function automatic blk_t iv(input logic wide);
		return wide ? '0 : {64{8'h01}};
	endfunction

endpackage

`default_nettype wire

// ===== src/streebog_hash_core.sv =====
// Message words are taken while idle; a full block then runs 25 lps passes (each a load
// then the eight output words of the shared lps unit), a fold, and 64-bit counter and sum adds.
// The final block adds a padding step and two more compressions, with the counter, then the sum;
// then the digest leaves at one word per cycle while m_tready is high (8 or 4 words).
// A new block is taken only once the previous block's work is done (s_tready low while busy).
// Reset (arst_n low) loads the all-zero iv, clears counters and selects 512-bit mode.
// ----------------------------------------------------------------------------
// streebog_hash_core
// Iterative streebog hash engine with a shared lps word unit and a 64-bit adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module streebog_hash_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // message_word
	input  wire logic        s_tlast,   // final_block
	input  wire logic [7:0]  s_tuser,   // tail_bytes [5:0], zero fill
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [63:0] m_tdata,   // digest_word
	output logic             m_tlast    // digest_last
);

	sbh_pkg::state_t state_q, state_d;
	sbh_pkg::phase_t phase_q;
	sbh_pkg::job_t   job_q;
	logic [3:0]      round_q;
	logic [2:0]      cnt_q;
	logic [2:0]      pos_q;
	logic            final_q;
	logic [5:0]      tail_q;
	logic            carry_q;
	logic            wide_q;
	sbh_pkg::blk_t   chain_q, nctr_q, sum_q, buf_q, key_q, st_q, src_q;

	sbh_pkg::blk_t   msg, ctr, load_src, padded;
	logic [63:0]     lps_w;
	logic [2:0]      idx, last_idx;
	logic [63:0]     add_a, add_b;
	logic [64:0]     add_r;
	logic            cfg_wr;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign prdata   = (paddr[2] == 1'b0) ? {31'b0, wide_q} : 32'b0;
	assign s_tready = (state_q == sbh_pkg::ST_IDLE);
	assign m_tvalid = (state_q == sbh_pkg::ST_OUT);
	assign last_idx = wide_q ? 3'd7 : 3'd3;
	assign m_tdata  = chain_q[cnt_q];
	assign m_tlast  = (cnt_q == last_idx);
	assign idx      = 3'(3'd7 - cnt_q);
	assign lps_w    = sbh_pkg::lps_word(src_q, cnt_q);

	always_comb begin
		case (job_q)
			sbh_pkg::JOB_CNT: msg = nctr_q;
			sbh_pkg::JOB_SUM: msg = sum_q;
			default:          msg = buf_q;
		endcase
		ctr = (job_q == sbh_pkg::JOB_BLOCK) ? nctr_q : '0;
		case (phase_q)
			sbh_pkg::PH_SLPS: load_src = st_q;
			sbh_pkg::PH_KLPS: begin
				for (int j = 0; j < 8; j++) begin
					load_src[j] = key_q[j] ^ sbh_pkg::RC[round_q][j];
				end
			end
			default: load_src = chain_q ^ ctr;
		endcase
	end

	// padding: 0x01 just ahead of the kept tail, zeros before it
	always_comb begin
		padded = buf_q;
		for (int p = 0; p < 64; p++) begin
			if (p + int'(tail_q) < 64) begin
				padded[p/8][(7-(p%8))*8 +: 8] = (p + int'(tail_q) == 63) ? 8'h01 : 8'h00;
			end
		end
	end

	// shared 64-bit adder, least significant word first
	always_comb begin
		if (state_q == sbh_pkg::ST_ADDN) begin
			add_a = nctr_q[idx];
			add_b = (idx == 3'd7) ? (final_q ? {55'b0, tail_q, 3'b000} : 64'd512) : 64'd0;
		end else begin
			add_a = sum_q[idx];
			add_b = buf_q[idx];
		end
		add_r = {1'b0, add_a} + {1'b0, add_b} + {64'b0, (cnt_q != 3'd0) && carry_q};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sbh_pkg::ST_IDLE: begin
				if (s_tvalid && pos_q == 3'd7) begin
					state_d = s_tlast ? sbh_pkg::ST_PAD : sbh_pkg::ST_LOAD;
				end
			end
			sbh_pkg::ST_PAD:  state_d = sbh_pkg::ST_LOAD;
			sbh_pkg::ST_LOAD: state_d = sbh_pkg::ST_LPS;
			sbh_pkg::ST_LPS: begin
				if (cnt_q == 3'd7) begin
					if (phase_q == sbh_pkg::PH_KLPS && round_q == 4'(sbh_pkg::ROUNDS - 1)) begin
						state_d = sbh_pkg::ST_FOLD;
					end else begin
						state_d = sbh_pkg::ST_LOAD;
					end
				end
			end
			sbh_pkg::ST_FOLD: begin
				case (job_q)
					sbh_pkg::JOB_BLOCK: state_d = sbh_pkg::ST_ADDN;
					sbh_pkg::JOB_CNT:   state_d = sbh_pkg::ST_LOAD;
					default:            state_d = sbh_pkg::ST_OUT;
				endcase
			end
			sbh_pkg::ST_ADDN: begin
				if (cnt_q == 3'd7) state_d = sbh_pkg::ST_ADDS;
			end
			sbh_pkg::ST_ADDS: begin
				if (cnt_q == 3'd7) state_d = final_q ? sbh_pkg::ST_LOAD : sbh_pkg::ST_IDLE;
			end
			sbh_pkg::ST_OUT: begin
				if (m_tready && m_tlast) state_d = sbh_pkg::ST_IDLE;
			end
			default: state_d = sbh_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbh_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sbh_pkg::PH_KINIT;
			job_q   <= sbh_pkg::JOB_BLOCK;
			round_q <= '0;
			cnt_q   <= '0;
			pos_q   <= '0;
			final_q <= 1'b0;
			tail_q  <= '0;
			carry_q <= 1'b0;
			wide_q  <= 1'b1;
			chain_q <= sbh_pkg::iv(1'b1);
			nctr_q  <= '0;
			sum_q   <= '0;
		end else begin
			unique case (state_q)
				sbh_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						buf_q[pos_q] <= s_tdata;
						pos_q        <= 3'(pos_q + 3'd1);
						if (pos_q == 3'd7) begin
							final_q <= s_tlast;
							tail_q  <= s_tuser[5:0];
							job_q   <= sbh_pkg::JOB_BLOCK;
							phase_q <= sbh_pkg::PH_KINIT;
						end
					end
				end
				sbh_pkg::ST_PAD: buf_q <= padded;
				sbh_pkg::ST_LOAD: begin
					src_q <= load_src;
					cnt_q <= '0;
				end
				sbh_pkg::ST_LPS: begin
					cnt_q <= 3'(cnt_q + 3'd1);
					unique case (phase_q)
						sbh_pkg::PH_KINIT: begin
							key_q[cnt_q] <= lps_w;
							st_q[cnt_q]  <= lps_w ^ msg[cnt_q];
							if (cnt_q == 3'd7) begin
								phase_q <= sbh_pkg::PH_SLPS;
								round_q <= '0;
							end
						end
						sbh_pkg::PH_SLPS: begin
							st_q[cnt_q] <= lps_w;
							if (cnt_q == 3'd7) phase_q <= sbh_pkg::PH_KLPS;
						end
						sbh_pkg::PH_KLPS: begin
							key_q[cnt_q] <= lps_w;
							st_q[cnt_q]  <= st_q[cnt_q] ^ lps_w;
							if (cnt_q == 3'd7) begin
								phase_q <= sbh_pkg::PH_SLPS;
								round_q <= (round_q == 4'(sbh_pkg::ROUNDS - 1)) ? 4'd0
									: 4'(round_q + 4'd1);
							end
						end
						default: phase_q <= sbh_pkg::PH_KINIT;
					endcase
				end
				sbh_pkg::ST_FOLD: begin
					chain_q <= chain_q ^ st_q ^ msg;
					cnt_q   <= '0;
					phase_q <= sbh_pkg::PH_KINIT;
					if (job_q == sbh_pkg::JOB_CNT) job_q <= sbh_pkg::JOB_SUM;
				end
				sbh_pkg::ST_ADDN: begin
					nctr_q[idx] <= add_r[63:0];
					carry_q     <= add_r[64];
					cnt_q       <= 3'(cnt_q + 3'd1);
				end
				sbh_pkg::ST_ADDS: begin
					sum_q[idx] <= add_r[63:0];
					carry_q    <= add_r[64];
					cnt_q      <= 3'(cnt_q + 3'd1);
					if (cnt_q == 3'd7 && final_q) job_q <= sbh_pkg::JOB_CNT;
				end
				sbh_pkg::ST_OUT: begin
					if (m_tready) begin
						cnt_q <= 3'(cnt_q + 3'd1);
						if (m_tlast) begin
							chain_q <= sbh_pkg::iv(wide_q);
							nctr_q  <= '0;
							sum_q   <= '0;
							pos_q   <= '0;
							cnt_q   <= '0;
						end
					end
				end
				default: cnt_q <= '0;
			endcase
			// register write restarts the message
			if (cfg_wr) begin
				wide_q  <= pwdata[0];
				chain_q <= sbh_pkg::iv(pwdata[0]);
				nctr_q  <= '0;
				sum_q   <= '0;
				pos_q   <= '0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/sbh_check.sv =====
// ----------------------------------------------------------------------------
// sbh_check
// Port-level checks on the streebog core, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "streebog_hash_core_assert.svh"

module sbh_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata,
	input wire logic        m_tlast
);

	// input is never taken while a digest is on offer
	`SBH_ASSERT_NEVER(a_no_overlap, clk, arst_n, s_tready && m_tvalid)

	// the last digest word ends the output burst
	`SBH_ASSERT_NEXT(a_last_ends, clk, arst_n, m_tvalid && m_tready && m_tlast, !m_tvalid)

	// a stalled digest word holds
	`SBH_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// a non-last digest word is followed by more digest output, with input still closed
	`SBH_ASSERT_NEXT(a_busy_after_out, clk, arst_n, m_tvalid && m_tready && !m_tlast,
		m_tvalid && !s_tready)

endmodule

bind streebog_hash_core sbh_check u_sbh_check (.*);

`default_nettype wire
